// ----- rtl/core/complex_arithmetic_unit_top_assert.svh -----
// Assertion macros for the complex arithmetic unit checker.
// Used by the checker file; expects clk and rst in the scope of use.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define CAU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cau_pkg.sv -----
// Shared types, codes, tables and saturation helpers for the complex ALU.
// No dependencies.
package cau_pkg;

  // operation codes carried on the action field
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MOD  = 3'd4,
    OP_ARG  = 3'd5,
    OP_CONJ = 3'd6
  } op_t;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // one cell per quotient / root bit
  localparam int NUM_CELLS = 32;

  // angles with 32 fraction bits
  localparam logic signed [39:0] PI_Z      = 40'sd13493037705;
  localparam logic signed [39:0] HALF_PI_Z = 40'sd6746518852;

  // atan(2^-i), 32 fraction bits
  localparam logic [31:0] ATAN_Q32 [NUM_CELLS] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  // data carried down the cell chain
  typedef struct packed {
    op_t                op;
    logic [31:0]        q_re;     // finished result for the short operations
    logic [31:0]        q_im;
    logic [1:0]         q_st;
    logic               neg_re;   // division sign and special flags
    logic               neg_im;
    logic               ovf_re;
    logic               ovf_im;
    logic               dz;
    logic [63:0]        den;
    logic [63:0]        r_re;     // partial remainders
    logic [63:0]        r_im;
    logic [31:0]        d_re;     // dividend bits in, quotient bits out
    logic [31:0]        d_im;
    logic [63:0]        sq_n;     // radicand, two bits leave per cell
    logic [33:0]        sq_rem;
    logic [31:0]        sq_root;
    logic               c_en;     // rotation active
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [39:0] cz;
  } cell_data_t;

  // clamp a 33-bit signed value to 32 bits; msb of result is the clamp flag
  function automatic logic [32:0] sat_s33(input logic signed [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) begin
      r = {1'b1, (v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // sign and magnitude to 32-bit two's complement with clamp flag
  function automatic logic [32:0] sat_sm(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else                     r = {1'b0, mag[31:0]};
    end else begin
      if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else                     r = {1'b0, 32'(32'd0 - mag[31:0])};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/complex_arithmetic_unit_top.sv -----
// Complex-number ALU on signed fixed point operands.
// Input channel in_valid/in_ready carries one beat: action, a_re, a_im,
// b_re, b_im. Output channel out_valid/out_ready carries res_re, res_im and
// status (ok, clamped, division by zero).
// A beat passes through four front stages (products, sums, sign split,
// setup), a chain of 32 cells and the output register. The chain length is
// set by the 32 quotient bits of the divider and the 32 bits of the square
// root, one bit per cell; the angle rotation uses the first ANGLE_ITERATIONS
// cells. Throughput is one beat per cycle while the receiver takes results,
// with no dependence between beats.
// Every stage holds its own valid bit and ready ripples back, so a stalled
// receiver only stops the stages that are full: bubbles keep closing up and
// new beats are taken until the whole pipe is occupied.
// Reset clears all valid bits; the pipe is empty and in_ready is high in the
// first cycle after reset.
// Depends on cau_pkg, cau_front, cau_cell and cau_finish.
module complex_arithmetic_unit_top #(
  parameter int FRAC_BITS        = 16,
  parameter int ANGLE_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic [1:0]         status
);
  import cau_pkg::*;

  cell_data_t chain_data  [NUM_CELLS+1];
  logic       chain_valid [NUM_CELLS+1];
  logic       chain_ready [NUM_CELLS+1];

  // front stages
  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  // cell chain
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    cau_cell #(
      .IDX              (g),
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_data  (chain_data[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_data  (chain_data[g+1])
    );
  end

  // result register
  cau_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (chain_valid[NUM_CELLS]),
    .up_ready  (chain_ready[NUM_CELLS]),
    .up_data   (chain_data[NUM_CELLS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_re    (res_re),
    .res_im    (res_im),
    .status    (status)
  );

endmodule

// ----- rtl/core/cau_cell.sv -----
// One step cell of the chain: a divider bit for both parts, a root bit and
// a rotation step. Depends on cau_pkg.
module cau_cell #(
  parameter int IDX              = 0,
  parameter int ANGLE_ITERATIONS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  cau_pkg::cell_data_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output cau_pkg::cell_data_t dn_data
);
  import cau_pkg::*;

  logic       valid;
  cell_data_t data;
  cell_data_t data_next;

  logic [63:0] t_re, t_im;
  logic [35:0] sq_t, sq_trial;
  logic signed [35:0] sx, sy;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  // one step of each iterative unit
  always_comb begin
    data_next = up_data;
    // restoring division, real part
    t_re = {up_data.r_re[62:0], up_data.d_re[31]};
    if (t_re >= up_data.den) begin
      data_next.r_re = t_re - up_data.den;
      data_next.d_re = {up_data.d_re[30:0], 1'b1};
    end else begin
      data_next.r_re = t_re;
      data_next.d_re = {up_data.d_re[30:0], 1'b0};
    end
    // restoring division, imaginary part
    t_im = {up_data.r_im[62:0], up_data.d_im[31]};
    if (t_im >= up_data.den) begin
      data_next.r_im = t_im - up_data.den;
      data_next.d_im = {up_data.d_im[30:0], 1'b1};
    end else begin
      data_next.r_im = t_im;
      data_next.d_im = {up_data.d_im[30:0], 1'b0};
    end
    // square root digit
    sq_t     = {up_data.sq_rem, up_data.sq_n[63:62]};
    sq_trial = {2'b00, up_data.sq_root, 2'b01};
    data_next.sq_n = {up_data.sq_n[61:0], 2'b00};
    if (sq_t >= sq_trial) begin
      data_next.sq_rem  = 34'(sq_t - sq_trial);
      data_next.sq_root = {up_data.sq_root[30:0], 1'b1};
    end else begin
      data_next.sq_rem  = 34'(sq_t);
      data_next.sq_root = {up_data.sq_root[30:0], 1'b0};
    end
    // vectoring rotation
    sx = up_data.cx >>> IDX;
    sy = up_data.cy >>> IDX;
    if (up_data.c_en && (IDX < ANGLE_ITERATIONS)) begin
      if (up_data.cy >= 0) begin
        data_next.cx = up_data.cx + sy;
        data_next.cy = up_data.cy - sx;
        data_next.cz = up_data.cz + $signed({8'd0, ATAN_Q32[IDX]});
      end else begin
        data_next.cx = up_data.cx - sy;
        data_next.cy = up_data.cy + sx;
        data_next.cz = up_data.cz - $signed({8'd0, ATAN_Q32[IDX]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ----- rtl/core/cau_front.sv -----
// Front end: products, sums, sign split and per-operation setup, four stages.
// Depends on cau_pkg.
module cau_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          action,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  output logic                dn_valid,
  input  logic                dn_ready,
  output cau_pkg::cell_data_t dn_data
);
  import cau_pkg::*;

  typedef struct packed {
    op_t                op;
    logic signed [63:0] p0, p1, p2, p3, p4, p5;
    logic [31:0]        q_re, q_im;
    logic [1:0]         q_st;
    logic               c_en;
    logic signed [35:0] cx, cy;
    logic signed [39:0] cz;
  } st1_t;

  typedef struct packed {
    op_t                op;
    logic [63:0]        s_a, s_b, s_c;
    logic [31:0]        q_re, q_im;
    logic [1:0]         q_st;
    logic               c_en;
    logic signed [35:0] cx, cy;
    logic signed [39:0] cz;
  } st2_t;

  typedef struct packed {
    op_t                op;
    logic               neg_a, neg_b;
    logic [63:0]        mag_a, mag_b, s_c;
    logic [31:0]        q_re, q_im;
    logic [1:0]         q_st;
    logic               c_en;
    logic signed [35:0] cx, cy;
    logic signed [39:0] cz;
  } st3_t;

  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  cell_data_t s4, s4_next;
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [31:0] m0, m1;
  logic [32:0] sr, si;
  logic [63:0] mq_re, mq_im;
  logic [32:0] mr, mi;

  // ready ripples back from the chain
  assign rdy4     = !v4 || dn_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign dn_valid = v4;
  assign dn_data  = s4;

  // stage 1: products, short operations, rotation setup
  always_comb begin
    s1_next    = '0;
    s1_next.op = op_t'(action);
    m0 = (op_t'(action) == OP_MOD) ? a_re : b_re;
    m1 = (op_t'(action) == OP_MOD) ? a_im : b_im;
    s1_next.p0 = 64'(a_re) * 64'(m0);
    s1_next.p1 = 64'(a_im) * 64'(m1);
    s1_next.p2 = 64'(a_im) * 64'(b_re);
    s1_next.p3 = 64'(a_re) * 64'(b_im);
    s1_next.p4 = 64'(b_re) * 64'(b_re);
    s1_next.p5 = 64'(b_im) * 64'(b_im);
    sr = '0;
    si = '0;
    unique case (op_t'(action))
      OP_ADD: begin
        sr = sat_s33(33'(a_re) + 33'(b_re));
        si = sat_s33(33'(a_im) + 33'(b_im));
      end
      OP_SUB: begin
        sr = sat_s33(33'(a_re) - 33'(b_re));
        si = sat_s33(33'(a_im) - 33'(b_im));
      end
      OP_CONJ: begin
        sr = {1'b0, a_re};
        si = sat_s33(33'sd0 - 33'(a_im));
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    s1_next.q_re = sr[31:0];
    s1_next.q_im = si[31:0];
    s1_next.q_st = (sr[32] || si[32]) ? ST_SAT : ST_OK;
    // angle setup: axis cases are settled here
    s1_next.cx = 36'(a_re);
    s1_next.cy = 36'(a_im);
    if (a_im == 32'sd0) begin
      s1_next.c_en = 1'b0;
      s1_next.cz   = (a_re < 0) ? PI_Z : 40'sd0;
    end else if (a_re == 32'sd0) begin
      s1_next.c_en = 1'b0;
      s1_next.cz   = (a_im > 0) ? HALF_PI_Z : -HALF_PI_Z;
    end else if (a_re < 0) begin
      s1_next.c_en = 1'b1;
      s1_next.cz   = (a_im > 0) ? PI_Z : -PI_Z;
      s1_next.cx   = -36'(a_re);
      s1_next.cy   = -36'(a_im);
    end else begin
      s1_next.c_en = 1'b1;
      s1_next.cz   = 40'sd0;
    end
  end

  // stage 2: sums of products
  always_comb begin
    s2_next.op   = s1.op;
    s2_next.q_re = s1.q_re;
    s2_next.q_im = s1.q_im;
    s2_next.q_st = s1.q_st;
    s2_next.c_en = s1.c_en;
    s2_next.cx   = s1.cx;
    s2_next.cy   = s1.cy;
    s2_next.cz   = s1.cz;
    if (s1.op == OP_MUL) begin
      s2_next.s_a = s1.p0 - s1.p1;
      s2_next.s_b = s1.p2 + s1.p3;
    end else begin
      s2_next.s_a = s1.p0 + s1.p1;
      s2_next.s_b = s1.p2 - s1.p3;
    end
    s2_next.s_c = (s1.op == OP_MOD) ? (s1.p0 + s1.p1) : (s1.p4 + s1.p5);
  end

  // stage 3: sign and magnitude
  always_comb begin
    s3_next.op    = s2.op;
    s3_next.q_re  = s2.q_re;
    s3_next.q_im  = s2.q_im;
    s3_next.q_st  = s2.q_st;
    s3_next.c_en  = s2.c_en;
    s3_next.cx    = s2.cx;
    s3_next.cy    = s2.cy;
    s3_next.cz    = s2.cz;
    s3_next.s_c   = s2.s_c;
    s3_next.neg_a = s2.s_a > 64'h8000_0000_0000_0000;
    s3_next.neg_b = s2.s_b > 64'h8000_0000_0000_0000;
    s3_next.mag_a = s3_next.neg_a ? (64'd0 - s2.s_a) : s2.s_a;
    s3_next.mag_b = s3_next.neg_b ? (64'd0 - s2.s_b) : s2.s_b;
  end

  // stage 4: product rounding, divider and root setup
  always_comb begin
    s4_next      = '0;
    s4_next.op   = s3.op;
    s4_next.q_re = s3.q_re;
    s4_next.q_im = s3.q_im;
    s4_next.q_st = s3.q_st;
    s4_next.c_en = s3.c_en;
    s4_next.cx   = s3.cx;
    s4_next.cy   = s3.cy;
    s4_next.cz   = s3.cz;
    mq_re = (s3.mag_a >> FRAC_BITS)
          + 64'(s3.neg_a && (s3.mag_a[FRAC_BITS-1:0] != '0));
    mq_im = (s3.mag_b >> FRAC_BITS)
          + 64'(s3.neg_b && (s3.mag_b[FRAC_BITS-1:0] != '0));
    mr = sat_sm(s3.neg_a, mq_re);
    mi = sat_sm(s3.neg_b, mq_im);
    if (s3.op == OP_MUL) begin
      s4_next.q_re = mr[31:0];
      s4_next.q_im = mi[31:0];
      s4_next.q_st = (mr[32] || mi[32]) ? ST_SAT : ST_OK;
    end
    s4_next.den    = s3.s_c;
    s4_next.dz     = (s3.s_c == 64'd0);
    s4_next.neg_re = s3.neg_a;
    s4_next.neg_im = s3.neg_b;
    s4_next.r_re   = s3.mag_a >> (32 - FRAC_BITS);
    s4_next.r_im   = s3.mag_b >> (32 - FRAC_BITS);
    s4_next.d_re   = 32'(s3.mag_a << FRAC_BITS);
    s4_next.d_im   = 32'(s3.mag_b << FRAC_BITS);
    s4_next.ovf_re = s4_next.r_re >= s3.s_c;
    s4_next.ovf_im = s4_next.r_im >= s3.s_c;
    s4_next.sq_n   = s3.s_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1 <= s1_next;
    if (rdy2 && v1)       s2 <= s2_next;
    if (rdy3 && v2)       s3 <= s3_next;
    if (rdy4 && v3)       s4 <= s4_next;
  end

endmodule

// ----- rtl/core/cau_finish.sv -----
// Output stage: final rounding and clamping, result register.
// Depends on cau_pkg.
module cau_finish #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  cau_pkg::cell_data_t up_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  res_re,
  output logic signed [31:0]  res_im,
  output logic [1:0]          status
);
  import cau_pkg::*;

  localparam logic signed [39:0] ANG_ROUND = 40'sd1 <<< (31 - FRAC_BITS);

  logic [31:0] re_next, im_next;
  logic [1:0]  st_next;
  logic [63:0] dq_re, dq_im;
  logic [32:0] dr, di;
  logic signed [39:0] zr;

  assign up_ready = !out_valid || out_ready;

  // per-operation result
  always_comb begin
    dq_re = up_data.ovf_re ? 64'h1_0000_0000
          : 64'(up_data.d_re) + 64'(up_data.neg_re && (up_data.r_re != 64'd0));
    dq_im = up_data.ovf_im ? 64'h1_0000_0000
          : 64'(up_data.d_im) + 64'(up_data.neg_im && (up_data.r_im != 64'd0));
    dr = sat_sm(up_data.neg_re, dq_re);
    di = sat_sm(up_data.neg_im, dq_im);
    zr = up_data.cz + ANG_ROUND;
    re_next = '0;
    im_next = '0;
    st_next = ST_OK;
    unique case (up_data.op)
      OP_ADD, OP_SUB, OP_MUL, OP_CONJ: begin
        re_next = up_data.q_re;
        im_next = up_data.q_im;
        st_next = up_data.q_st;
      end
      OP_DIV: begin
        if (up_data.dz) begin
          st_next = ST_DIVZ;
        end else begin
          re_next = dr[31:0];
          im_next = di[31:0];
          st_next = (dr[32] || di[32]) ? ST_SAT : ST_OK;
        end
      end
      OP_MOD: begin
        if (up_data.sq_root[31]) begin
          re_next = 32'h7FFF_FFFF;
          st_next = ST_SAT;
        end else begin
          re_next = up_data.sq_root;
        end
      end
      OP_ARG: begin
        re_next = 32'(zr >>> (32 - FRAC_BITS));
      end
      default: begin
        re_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_re <= re_next;
      res_im <= im_next;
      status <= st_next;
    end
  end

endmodule

// ----- rtl/core/cau_checker.sv -----
// Port-level checks for the complex ALU, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit_top_assert.svh.
`include "complex_arithmetic_unit_top_assert.svh"

module cau_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] res_re,
  input logic signed [31:0] res_im,
  input logic [1:0]         status
);
  import cau_pkg::*;

  // beats in flight
  logic [5:0] cnt;
  logic [5:0] cnt_next;

  always_comb begin
    cnt_next = cnt + 6'(in_valid && in_ready) - 6'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  `CAU_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(res_re) && $stable(res_im) && $stable(status), "result changed while stalled")
  `CAU_ASSERT_SAME(a_no_phantom, out_valid, cnt != 6'd0, "result beat with nothing in flight")
  `CAU_ASSERT_SAME(a_idle_ready, cnt == 6'd0, in_ready, "empty unit refuses input")
  `CAU_ASSERT_SAME(a_divz_zero, out_valid && (status == ST_DIVZ), (res_re == 32'sd0) && (res_im == 32'sd0), "division by zero with nonzero result")

endmodule

bind complex_arithmetic_unit_top cau_port_checker u_cau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .res_re    (res_re),
  .res_im    (res_im),
  .status    (status)
);
